>>> sv/adtf_pkg.sv
// ----------------------------------------------------------------------------
// adtf_pkg
// Shared constants for the ASCII decimal to fixed-point converter: character
// codes, the width of the fraction accumulator and its digit weight table.
// ----------------------------------------------------------------------------
package adtf_pkg;

  localparam int unsigned AccFracBits = 24;
  localparam int unsigned CharBits    = 8;

  localparam logic [CharBits-1:0] ChEnd   = 8'd0;
  localparam logic [CharBits-1:0] ChZero  = 8'd48;
  localparam logic [CharBits-1:0] ChNine  = 8'd57;
  localparam logic [CharBits-1:0] ChPoint = 8'd46;
  localparam logic [CharBits-1:0] ChMinus = 8'd45;

  typedef logic [AccFracBits-1:0] frac_acc_t;
  typedef logic [2:0]             frac_pos_t;

  // floor(2^24 / 10^k) for fraction digit k = 1..7; the last slot is unused
  localparam frac_acc_t FracWeight [8] = '{
    24'd1677721, 24'd167772, 24'd16777, 24'd1677,
    24'd167,     24'd16,     24'd1,     24'd0
  };

endpackage

>>> sv/ascii_decimal_to_fixed.sv
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed
// Converts an ASCII decimal string, one character per word, into a signed
// fixed-point number with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Input channel: one character per word on char_code_i. A code of zero ends
// the string; only that word produces a result word. A leading minus sets the
// sign, digits before a single point form the integer part (saturating, with
// overflow_o set), up to MAX_FRAC_DIGITS digits after the point form the
// fraction. Any other character marks the string invalid and the rest of the
// string is dropped; the value gathered so far is still reported.
// Throughput: one character per cycle unless the input is stalled. The
// per-character update (a times-ten shift-add on the integer part and a table
// add on the fraction) is combinational and feeds the parse state registers.
// The result for a terminator is registered and appears on the output in the
// cycle after the terminator is accepted.
// Reset clears the parse state and empties the result register. While a
// result waits on a stalled receiver the input is stalled as well.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned INT_BITS        = 32,
  parameter int unsigned MAX_FRAC_DIGITS = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [adtf_pkg::CharBits-1:0]       char_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [INT_BITS+FRAC_BITS-1:0] value_o,
  output logic                                invalid_o,
  output logic                                overflow_o
);

  localparam int unsigned IntMagBits = INT_BITS - 1;
  localparam int unsigned NextBits   = INT_BITS + 3;
  localparam int unsigned ValueBits  = INT_BITS + FRAC_BITS;
  localparam int unsigned FracDrop   = adtf_pkg::AccFracBits - FRAC_BITS;

  logic                   at_start_q, at_start_d;
  logic                   negative_q, negative_d;
  logic                   seen_point_q, seen_point_d;
  logic                   stopped_q, stopped_d;
  logic                   overflowed_q, overflowed_d;
  logic [IntMagBits-1:0]  int_acc_q, int_acc_d;
  adtf_pkg::frac_acc_t    frac_acc_q, frac_acc_d;
  adtf_pkg::frac_pos_t    frac_pos_q, frac_pos_d;

  logic                   out_valid_q, out_valid_d;
  logic [ValueBits-1:0]   value_q, value_d;
  logic                   invalid_q, overflow_q;

  logic                   in_accept;
  logic                   is_end, is_digit;
  logic [3:0]             digit;
  logic [NextBits-1:0]    int_next;
  logic [ValueBits-1:0]   mag;
  logic [FRAC_BITS-1:0]   frac_part;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign is_end   = (char_code_i == adtf_pkg::ChEnd);
  assign is_digit = (char_code_i >= adtf_pkg::ChZero) && (char_code_i <= adtf_pkg::ChNine);
  assign digit    = 4'(char_code_i - adtf_pkg::ChZero);

  assign int_next = (NextBits'(int_acc_q) << 3) + (NextBits'(int_acc_q) << 1)
                  + NextBits'(digit);

  assign frac_part = FRAC_BITS'(frac_acc_q >> FracDrop);
  assign mag       = {1'b0, int_acc_q, frac_part};
  assign value_d   = negative_q ? (ValueBits'(0) - mag) : mag;

  always_comb begin
    at_start_d   = at_start_q;
    negative_d   = negative_q;
    seen_point_d = seen_point_q;
    stopped_d    = stopped_q;
    overflowed_d = overflowed_q;
    int_acc_d    = int_acc_q;
    frac_acc_d   = frac_acc_q;
    frac_pos_d   = frac_pos_q;
    if (in_accept) begin
      priority if (is_end) begin
        at_start_d   = 1'b1;
        negative_d   = 1'b0;
        seen_point_d = 1'b0;
        stopped_d    = 1'b0;
        overflowed_d = 1'b0;
        int_acc_d    = '0;
        frac_acc_d   = '0;
        frac_pos_d   = '0;
      end else if (stopped_q) begin
        at_start_d = at_start_q;
      end else if (at_start_q && (char_code_i == adtf_pkg::ChMinus)) begin
        negative_d = 1'b1;
        at_start_d = 1'b0;
      end else begin
        at_start_d = 1'b0;
        priority if (is_digit) begin
          if (!seen_point_q) begin
            if (int_next[NextBits-1:IntMagBits] != '0) begin
              int_acc_d    = '1;
              overflowed_d = 1'b1;
            end else begin
              int_acc_d = int_next[IntMagBits-1:0];
            end
          end else if (frac_pos_q < 3'(MAX_FRAC_DIGITS)) begin
            frac_acc_d = frac_acc_q
                       + adtf_pkg::AccFracBits'(digit * adtf_pkg::FracWeight[frac_pos_q]);
            frac_pos_d = frac_pos_q + 3'd1;
          end
        end else if ((char_code_i == adtf_pkg::ChPoint) && !seen_point_q) begin
          seen_point_d = 1'b1;
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (in_accept && is_end) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q   <= 1'b1;
      negative_q   <= 1'b0;
      seen_point_q <= 1'b0;
      stopped_q    <= 1'b0;
      overflowed_q <= 1'b0;
      int_acc_q    <= '0;
      frac_acc_q   <= '0;
      frac_pos_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      at_start_q   <= at_start_d;
      negative_q   <= negative_d;
      seen_point_q <= seen_point_d;
      stopped_q    <= stopped_d;
      overflowed_q <= overflowed_d;
      int_acc_q    <= int_acc_d;
      frac_acc_q   <= frac_acc_d;
      frac_pos_q   <= frac_pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_end) begin
      value_q    <= value_d;
      invalid_q  <= stopped_q;
      overflow_q <= overflowed_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign invalid_o   = invalid_q;
  assign overflow_o  = overflow_q;

endmodule
